@@ rtl/ceb_pkg.sv @@
// Shared types and constants for the coincidence event builder.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package ceb_pkg;

    localparam int TIME_W        = 63;
    localparam int CHAN_W        = 8;
    localparam int WINDOW_W      = 31;
    localparam int MASK_W        = 4;
    localparam int REPORTED      = 4;
    localparam int NUM_CHANNELS  = 4;
    localparam int IN_DATA_W     = 72;
    localparam int OUT_DATA_W    = 256;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 31'd10000;

    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        logic [TIME_W-1:0] timestamp;
    } hit_t;

    typedef struct packed {
        logic [MASK_W-1:0] hit_mask;
        logic [TIME_W-1:0] time_ch4;
        logic [TIME_W-1:0] time_ch3;
        logic [TIME_W-1:0] time_ch2;
        logic [TIME_W-1:0] time_ch1;
    } event_t;

endpackage

@@ rtl/ceb_in_reg.sv @@
// Input register stage of the coincidence event builder.
// Holds one accepted hit until the event stage takes it; uses ceb_pkg.
`timescale 1ns / 1ps

module ceb_in_reg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ceb_pkg::hit_t in_hit,
    output logic          hit_valid,
    input  logic          hit_take,
    output ceb_pkg::hit_t hit
);

    logic          valid_reg;
    logic          valid_next;
    ceb_pkg::hit_t hit_reg;

    assign in_ready   = !valid_reg || hit_take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (hit_take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hit_reg <= in_hit;
        end
    end

    assign hit_valid = valid_reg;
    assign hit       = hit_reg;

endmodule

@@ rtl/ceb_core.sv @@
// Event stage: gap test, slot update and the registered result.
// Takes hits from ceb_in_reg and holds the window register; uses ceb_pkg.
`timescale 1ns / 1ps

module ceb_core #(
    parameter int NUM_CHANNELS = ceb_pkg::NUM_CHANNELS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [ceb_pkg::WINDOW_W-1:0]   cfg_window,
    input  logic                           hit_valid,
    output logic                           hit_take,
    input  ceb_pkg::hit_t                  hit,
    output logic                           out_valid,
    input  logic                           out_ready,
    output ceb_pkg::event_t                out_event
);

    localparam int SLOT_W = $clog2(NUM_CHANNELS);
    localparam int CNT_W  = $clog2(NUM_CHANNELS + 1);
    localparam int TW     = ceb_pkg::TIME_W;

    logic [ceb_pkg::WINDOW_W-1:0] window_reg;
    logic [TW-1:0]                prev_time_reg;
    logic                         seen_any_reg;
    logic [NUM_CHANNELS-1:0]      slot_used_reg;
    logic [NUM_CHANNELS-1:0]      slot_used_next;
    logic                         event_clean_reg;
    logic                         event_clean_next;
    logic [TW-1:0]                slot_time_reg [NUM_CHANNELS];
    logic                         out_valid_reg;
    logic                         out_valid_next;
    ceb_pkg::event_t              out_event_reg;
    ceb_pkg::event_t              event_next;

    logic                         chan_ok;
    logic [SLOT_W-1:0]            slot;
    logic [NUM_CHANNELS-1:0]      bit_sel;
    logic [TW-1:0]                gap;
    logic                         close_event;
    logic                         emit;
    logic                         do_store;
    logic [CNT_W-1:0]             used_cnt;
    logic [ceb_pkg::TIME_W*ceb_pkg::REPORTED-1:0] rep_times;
    logic [ceb_pkg::MASK_W-1:0]   rep_mask;

    assign hit_take = hit_valid && (!out_valid_reg || out_ready);

    assign chan_ok = (hit.channel != '0) && (hit.channel <= ceb_pkg::CHAN_W'(NUM_CHANNELS));
    assign slot    = SLOT_W'(hit.channel - 8'd1);
    assign bit_sel = NUM_CHANNELS'(1) << slot;
    assign gap     = hit.timestamp - prev_time_reg;

    assign close_event = seen_any_reg && (hit.timestamp > prev_time_reg)
                      && (gap > {{(TW - ceb_pkg::WINDOW_W){1'b0}}, window_reg});

    always_comb
    begin
        used_cnt = '0;
        for (int k = 0; k < NUM_CHANNELS; k++)
        begin
            used_cnt = used_cnt + CNT_W'(slot_used_reg[k]);
        end
    end

    assign emit = close_event && event_clean_reg && (used_cnt >= CNT_W'(2));

    genvar g;
    generate
        for (g = 0; g < ceb_pkg::REPORTED; g++)
        begin : g_rep
            if (g < NUM_CHANNELS)
            begin : g_on
                assign rep_times[g*TW +: TW] = slot_used_reg[g] ? slot_time_reg[g] : '0;
                assign rep_mask[g]           = slot_used_reg[g];
            end
            else
            begin : g_off
                assign rep_times[g*TW +: TW] = '0;
                assign rep_mask[g]           = 1'b0;
            end
        end
    endgenerate

    assign event_next = {rep_mask, rep_times};

    always_comb
    begin
        slot_used_next   = slot_used_reg;
        event_clean_next = event_clean_reg;
        do_store         = 1'b0;
        priority if (close_event)
        begin
            slot_used_next   = bit_sel;
            event_clean_next = 1'b1;
            do_store         = 1'b1;
        end
        else if ((slot_used_reg & bit_sel) != '0)
        begin
            event_clean_next = 1'b0;
        end
        else
        begin
            slot_used_next = slot_used_reg | bit_sel;
            do_store       = 1'b1;
        end
    end

    always_comb
    begin
        if (hit_take)
        begin
            out_valid_next = chan_ok && emit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg      <= ceb_pkg::WINDOW_RESET;
            prev_time_reg   <= '0;
            seen_any_reg    <= 1'b0;
            slot_used_reg   <= '0;
            event_clean_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                window_reg <= cfg_window;
            end
            if (hit_take && chan_ok)
            begin
                prev_time_reg   <= hit.timestamp;
                seen_any_reg    <= 1'b1;
                slot_used_reg   <= slot_used_next;
                event_clean_reg <= event_clean_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit_take && chan_ok && do_store)
        begin
            slot_time_reg[slot] <= hit.timestamp;
        end
        if (hit_take && chan_ok && emit)
        begin
            out_event_reg <= event_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_event = out_event_reg;

    a_idle_state: assert property (@(posedge clk) disable iff (!rst_n)
        !seen_any_reg |-> (slot_used_reg == '0) && !event_clean_reg)
        else $error("State changed before the first hit.");

    a_open_event: assert property (@(posedge clk) disable iff (!rst_n)
        seen_any_reg |-> (slot_used_reg != '0))
        else $error("Open event has no filled slot.");

    a_ignored_hit: assert property (@(posedge clk) disable iff (!rst_n)
        hit_take && !chan_ok |=> $stable(slot_used_reg) && $stable(prev_time_reg)
                              && $stable(event_clean_reg))
        else $error("Ignored channel changed the event state.");

    a_mask_two: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (NUM_CHANNELS > ceb_pkg::REPORTED)
                       || ($countones(out_event_reg.hit_mask) >= 2))
        else $error("Result with fewer than two channels.");

    a_emit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(event_clean_reg))
        else $error("Result from an event that was not clean.");

endmodule

@@ rtl/coincidence_event_builder.sv @@
// Top level of the coincidence event builder.
// Joins ceb_in_reg and ceb_core; uses ceb_pkg.
`timescale 1ns / 1ps

// The block groups time-tagger hits into coincidence events.
// Hits arrive on the s_axis channel, one transfer per hit; hits on channels
// outside 1 to NUM_CHANNELS are dropped without touching any state.
// A hit more than the window after the previous kept hit closes the open
// event; a closed event that is clean and has at least two channels leaves
// on the m_axis channel as four slot times and a hit mask.
// The window is written on the cfg channel, which is always ready, and
// should be changed only while no hit is in flight.
// A result is registered after the hit that closes its event has passed the input register.
// Throughput is one hit per cycle while the receiver is ready, set by the single gap
// subtract and compare that sits between the input register and the result register.
// When the receiver stalls, the result register holds its event and the
// input register holds one more hit; s_axis_tready then falls.
// Reset clears the event state and loads the window with 10000 ps.

module coincidence_event_builder #(
    parameter int NUM_CHANNELS = ceb_pkg::NUM_CHANNELS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ceb_pkg::WINDOW_W-1:0]      cfg_data,     // gap window in ps
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ceb_pkg::IN_DATA_W-1:0]     s_axis_tdata, // timestamp, channel, pad
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ceb_pkg::OUT_DATA_W-1:0]    m_axis_tdata  // time_ch1..4, hit_mask
);

    ceb_pkg::hit_t   in_hit;
    ceb_pkg::hit_t   hit;
    logic            hit_valid;
    logic            hit_take;
    ceb_pkg::event_t out_event;

    assign cfg_ready = 1'b1;
    assign in_hit    = s_axis_tdata[ceb_pkg::TIME_W+ceb_pkg::CHAN_W-1:0];

    ceb_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_hit    (in_hit),
        .hit_valid (hit_valid),
        .hit_take  (hit_take),
        .hit       (hit)
    );

    ceb_core #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_window (cfg_data),
        .hit_valid  (hit_valid),
        .hit_take   (hit_take),
        .hit        (hit),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_event  (out_event)
    );

    assign m_axis_tdata = out_event;

endmodule

@@ dv/tb_coincidence_event_builder.sv @@
// Self-checking testbench for the coincidence event builder: directed and random hit streams.
// It predicts every event with its own model and compares each one field by field.
// Depends on rtl/ceb_pkg.sv and rtl/coincidence_event_builder.sv.
`timescale 1ns / 1ps

module tb_coincidence_event_builder;

    localparam int TIME_W       = ceb_pkg::TIME_W;
    localparam int CHAN_W       = ceb_pkg::CHAN_W;
    localparam int WINDOW_W     = ceb_pkg::WINDOW_W;
    localparam int MASK_W       = ceb_pkg::MASK_W;
    localparam int NUM_CHANNELS = ceb_pkg::NUM_CHANNELS;
    localparam int IN_DATA_W    = ceb_pkg::IN_DATA_W;
    localparam int OUT_DATA_W   = ceb_pkg::OUT_DATA_W;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = ceb_pkg::WINDOW_RESET;

    typedef ceb_pkg::event_t event_t;

    localparam int MIN_CHANNEL     = 1;
    localparam int SETTLE_CYCLES   = 8;
    localparam int TAIL_CYCLES     = 10;
    localparam int STALL_LIMIT     = 5000;
    localparam int PHASE_COUNT     = 6;
    localparam int PHASE_HITS      = 213;
    localparam int IDLE_LOW        = 35;
    localparam int IDLE_HIGH       = 69;
    localparam logic [TIME_W-1:0]   TIME_MAX   = {TIME_W{1'b1}};
    localparam logic [WINDOW_W-1:0] WINDOW_MAX = {WINDOW_W{1'b1}};

    class event_scoreboard;
        logic [WINDOW_W-1:0]     window;
        logic [TIME_W-1:0]       prev_ts;
        bit                      started;
        logic [TIME_W-1:0]       slot_ts [NUM_CHANNELS];
        logic [NUM_CHANNELS-1:0] slot_mask;
        bit                      clean;
        event_t                  expected_events [$];
        int                      errors;

        function new();
            window    = WINDOW_RESET;
            prev_ts   = '0;
            started   = 1'b0;
            for (int k = 0; k < NUM_CHANNELS; k++)
            begin
                slot_ts[k] = '0;
            end
            slot_mask = '0;
            clean     = 1'b0;
            errors    = 0;
        endfunction

        function void set_window(logic [WINDOW_W-1:0] value);
            window = value;
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Groups one accepted hit and queues the event that it closes, if any.
        function void note_hit(logic [TIME_W-1:0] ts, logic [CHAN_W-1:0] ch);
            int unsigned             idx;
            logic [NUM_CHANNELS-1:0] onehot;
            logic [TIME_W-1:0]       gap;
            bit                      closes;
            event_t                  ev;
            if (ch < MIN_CHANNEL || ch > NUM_CHANNELS)
            begin
                return;
            end
            idx    = ch - MIN_CHANNEL;
            onehot = '0;
            onehot[idx] = 1'b1;
            gap    = ts - prev_ts;
            closes = started && (ts > prev_ts) && (gap > window);
            prev_ts = ts;
            started = 1'b1;
            if (closes)
            begin
                if (clean && $countones(slot_mask) >= 2)
                begin
                    ev.time_ch1 = slot_mask[0] ? slot_ts[0] : '0;
                    ev.time_ch2 = slot_mask[1] ? slot_ts[1] : '0;
                    ev.time_ch3 = slot_mask[2] ? slot_ts[2] : '0;
                    ev.time_ch4 = slot_mask[3] ? slot_ts[3] : '0;
                    ev.hit_mask = slot_mask[MASK_W-1:0];
                    expected_events.push_back(ev);
                end
                clean = 1'b1;
                for (int k = 0; k < NUM_CHANNELS; k++)
                begin
                    slot_ts[k] = '0;
                end
                slot_mask    = onehot;
                slot_ts[idx] = ts;
            end
            else if ((slot_mask & onehot) != 0)
            begin
                clean = 1'b0;
            end
            else
            begin
                slot_mask    = slot_mask | onehot;
                slot_ts[idx] = ts;
            end
        endfunction

        task compare_field(string name, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
            if (got !== want)
            begin
                report($sformatf("%s is %h, expected %h", name, got, want));
            end
        endtask

        task check_event(logic [OUT_DATA_W-1:0] data);
            event_t got;
            event_t want;
            got = event_t'(data);
            if (expected_events.size() == 0)
            begin
                report($sformatf("event transfer with no event expected, data %h", data));
                return;
            end
            want = expected_events.pop_front();
            compare_field("time_ch1", got.time_ch1, want.time_ch1);
            compare_field("time_ch2", got.time_ch2, want.time_ch2);
            compare_field("time_ch3", got.time_ch3, want.time_ch3);
            compare_field("time_ch4", got.time_ch4, want.time_ch4);
            compare_field("hit_mask", TIME_W'(got.hit_mask), TIME_W'(want.hit_mask));
        endtask

        task check_empty();
            if (expected_events.size() != 0)
            begin
                report($sformatf("%0d expected events never arrived", expected_events.size()));
            end
        endtask
    endclass

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [WINDOW_W-1:0]    cfg_data      = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    event_scoreboard sb = new();
    int              src_idle    = IDLE_LOW;
    int              sink_idle   = IDLE_HIGH;
    int              stall_count = 0;

    coincidence_event_builder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_event(m_axis_tdata);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            stall_count <= 0;
        end
        else if (stall_count + 1 >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            stall_count <= stall_count + 1;
        end
    end

    task automatic send_hit(input logic [TIME_W-1:0] ts, input logic [CHAN_W-1:0] ch);
        while ($urandom_range(0, 99) < src_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, ch, ts};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_hit(ts, ch);
        @(negedge clk);
    endtask

    task automatic drain_events();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_window(input logic [WINDOW_W-1:0] value);
        drain_events();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_window(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [TIME_W-1:0] next_time(input logic [TIME_W-1:0] cur,
                                                    input logic [WINDOW_W-1:0] w);
        logic [63:0] r64;
        logic [63:0] gap;
        int unsigned pick;
        r64  = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 45)
            gap = r64 % ({33'b0, w} + 64'd1);
        else if (pick < 55)
            gap = {33'b0, w};
        else if (pick < 62)
            gap = {33'b0, w} + 64'd1;
        else if (pick < 85)
            gap = {33'b0, w} + 64'd1 + (r64 % 64'd5000);
        else if (pick < 93)
            return cur - TIME_W'(r64 % 64'd5000);
        else
            return r64[TIME_W-1:0];
        return cur + gap[TIME_W-1:0];
    endfunction

    function automatic logic [CHAN_W-1:0] pick_channel();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 85)
            return CHAN_W'($urandom_range(MIN_CHANNEL, NUM_CHANNELS));
        else if (pick < 93)
            return '0;
        else
            return CHAN_W'($urandom_range(0, 255));
    endfunction

    initial
    begin
        logic [TIME_W-1:0]   t;
        logic [WINDOW_W-1:0] w;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset window of 10000 ps; ignored channels before the first hit.
        send_hit(63'd50, 8'd0);
        send_hit(63'd60, 8'd5);
        send_hit(63'd70, 8'd255);
        send_hit(63'd100, 8'd1);
        send_hit(63'd200, 8'd2);
        send_hit(63'd20000, 8'd3);
        send_hit(63'd20050, 8'd4);
        send_hit(63'd20100, 8'd1);
        send_hit(63'd40000, 8'd2);
        send_hit(63'd40010, 8'd2);
        send_hit(63'd60000, 8'd1);
        send_hit(63'd80000, 8'd3);
        send_hit(63'd70000, 8'd4);
        send_hit(TIME_MAX, 8'd200);
        send_hit(63'd80000, 8'd1);
        send_hit(63'd90001, 8'd2);
        send_hit(63'd90002, 8'd3);
        send_hit(TIME_MAX, 8'd4);
        send_hit(TIME_MAX, 8'd1);
        send_hit(63'd0, 8'd0);
        send_hit(63'd0, 8'd2);
        send_hit(TIME_MAX, 8'd3);
        drain_events();

        t = {$urandom, $urandom};
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            unique case (phase)
                0: w = '0;
                1: w = WINDOW_MAX;
                2: w = WINDOW_W'($urandom_range(1, 100000));
                3: w = WINDOW_RESET;
                4: w = WINDOW_W'(1);
                default: w = WINDOW_W'($urandom);
            endcase
            write_window(w);
            unique case (phase / 2)
                0:
                begin
                    src_idle  = IDLE_LOW;
                    sink_idle = IDLE_HIGH;
                end
                1:
                begin
                    src_idle  = IDLE_HIGH;
                    sink_idle = IDLE_LOW;
                end
                default:
                begin
                    src_idle  = 0;
                    sink_idle = 0;
                end
            endcase
            for (int n = 0; n < PHASE_HITS; n++)
            begin
                if (n == PHASE_HITS / 2)
                begin
                    drain_events();
                end
                t = next_time(t, w);
                send_hit(t, pick_channel());
            end
        end

        drain_events();
        repeat (TAIL_CYCLES) @(posedge clk);
        sb.check_empty();
        if (sb.errors == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
